// ===== rtl/periodic_boundary_unit_assert.svh =====
// Assertion macros for the periodic boundary unit.
// Needs a clock and an active-low reset name at the point of use.
`ifndef PERIODIC_BOUNDARY_UNIT_ASSERT_SVH
`define PERIODIC_BOUNDARY_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PBU_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("periodic boundary check failed");

// Next-cycle implication.
`define PBU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("periodic boundary check failed");

`endif

// ===== rtl/pbu_pkg.sv =====
// Types, constants and saturation helpers for the periodic boundary unit.
// No dependencies.
package pbu_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int IMAGE_WIDTH = 16;
    localparam int NUM_AXES    = 3;
    localparam int SIZE_WIDTH  = COORD_WIDTH + 1;
    localparam int WIDE_WIDTH  = COORD_WIDTH + 2;
    localparam int IMG_WIDE    = IMAGE_WIDTH + 1;

    localparam int IMG_BASE    = NUM_AXES * COORD_WIDTH;
    localparam int DATA_BITS   = NUM_AXES * (COORD_WIDTH + IMAGE_WIDTH);
    localparam int TDATA_WIDTH = ((DATA_BITS + 7) / 8) * 8;

    localparam int REG_IDX_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [SIZE_WIDTH-1:0]  t_size;
    typedef logic signed [WIDE_WIDTH-1:0]  t_wide;
    typedef logic signed [IMAGE_WIDTH-1:0] t_image;
    typedef logic signed [IMG_WIDE-1:0]    t_image_wide;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_LOWER_X = 3'd0,
        REG_LOWER_Y = 3'd1,
        REG_LOWER_Z = 3'd2,
        REG_UPPER_X = 3'd3,
        REG_UPPER_Y = 3'd4,
        REG_UPPER_Z = 3'd5,
        REG_PERIODIC_MASK = 3'd6
    } t_reg_idx;

    typedef enum logic {
        CMD_WRAP = 1'b0,
        CMD_MIN_IMAGE = 1'b1
    } t_cmd;

    localparam t_wide COORD_MAX_W = t_wide'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam t_wide COORD_MIN_W = -COORD_MAX_W - t_wide'(1);
    localparam t_coord COORD_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam t_image_wide IMG_MAX_W = t_image_wide'({1'b0, {(IMAGE_WIDTH-1){1'b1}}});
    localparam t_image_wide IMG_MIN_W = -IMG_MAX_W - t_image_wide'(1);
    localparam t_image IMG_MAX = {1'b0, {(IMAGE_WIDTH-1){1'b1}}};
    localparam t_image IMG_MIN = {1'b1, {(IMAGE_WIDTH-1){1'b0}}};

    function automatic t_coord clamp_coord(input t_wide v);
        t_coord r;
        if (v > COORD_MAX_W) begin
            r = COORD_MAX;
        end else if (v < COORD_MIN_W) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic t_image clamp_image(input t_image_wide v);
        t_image r;
        if (v > IMG_MAX_W) begin
            r = IMG_MAX;
        end else if (v < IMG_MIN_W) begin
            r = IMG_MIN;
        end else begin
            r = v[IMAGE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/periodic_boundary_unit.sv =====
// Periodic boundary unit: position wrap and minimum-image separation fix.
// Depends on pbu_pkg and periodic_boundary_unit_assert.svh.
//
//  channel   dir  handshake                  content
//  s (item)  in   i_s_tvalid / o_s_tready    tdata coords + counters, tuser command
//  m (res)   out  o_m_tvalid / i_m_tready    tdata results + counters, tuser rebuild
//  cfg       in   i_cfg_valid / o_cfg_ready  register index + data
//
// One item per cycle unless the result stalls. Items pass from the input
// register to the result register, with the per-axis compare and saturating
// add between them. Box size and half size come from registers updated in
// the cycle after a configuration write. Synchronous active-low reset clears
// both pipeline valids and all configuration. A stalled result holds its
// register; with both registers full, o_s_tready drops until it transfers.
module periodic_boundary_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // coord_x, coord_y, coord_z, image_in_x, image_in_y, image_in_z
    input  logic [pbu_pkg::TDATA_WIDTH-1:0]  i_s_tdata,
    // command
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // result_x, result_y, result_z, image_out_x, image_out_y, image_out_z
    output logic [pbu_pkg::TDATA_WIDTH-1:0]  o_m_tdata,
    // rebuild_needed
    output logic                             o_m_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pbu_pkg::REG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [pbu_pkg::COORD_WIDTH-1:0]  i_cfg_data
);

    pbu_pkg::t_coord  r_lower [pbu_pkg::NUM_AXES];
    pbu_pkg::t_coord  r_upper [pbu_pkg::NUM_AXES];
    logic [pbu_pkg::NUM_AXES-1:0] r_mask;

    pbu_pkg::t_size   n_size     [pbu_pkg::NUM_AXES];
    pbu_pkg::t_size   r_size     [pbu_pkg::NUM_AXES];
    pbu_pkg::t_coord  r_half     [pbu_pkg::NUM_AXES];
    pbu_pkg::t_size   r_neg_half [pbu_pkg::NUM_AXES];

    logic             r_in_valid;
    pbu_pkg::t_cmd    r_in_cmd;
    pbu_pkg::t_coord  r_in_coord [pbu_pkg::NUM_AXES];
    pbu_pkg::t_image  r_in_img   [pbu_pkg::NUM_AXES];

    logic             r_out_valid;
    pbu_pkg::t_cmd    r_out_cmd;
    logic             r_out_rebuild;
    pbu_pkg::t_coord  r_out_coord [pbu_pkg::NUM_AXES];
    pbu_pkg::t_image  r_out_img   [pbu_pkg::NUM_AXES];

    pbu_pkg::t_coord  n_coord [pbu_pkg::NUM_AXES];
    pbu_pkg::t_image  n_img   [pbu_pkg::NUM_AXES];
    logic [pbu_pkg::NUM_AXES-1:0] n_wrapped;

    logic             out_free;
    logic             advance;
    logic             s_xfer;

    assign out_free    = !r_out_valid || i_m_tready;
    assign advance     = r_in_valid && out_free;
    assign o_s_tready  = !r_in_valid || out_free;
    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < pbu_pkg::NUM_AXES; a++) begin
                r_lower[a] <= '0;
                r_upper[a] <= '0;
            end
            r_mask <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pbu_pkg::REG_LOWER_X:       r_lower[0] <= i_cfg_data;
                pbu_pkg::REG_LOWER_Y:       r_lower[1] <= i_cfg_data;
                pbu_pkg::REG_LOWER_Z:       r_lower[2] <= i_cfg_data;
                pbu_pkg::REG_UPPER_X:       r_upper[0] <= i_cfg_data;
                pbu_pkg::REG_UPPER_Y:       r_upper[1] <= i_cfg_data;
                pbu_pkg::REG_UPPER_Z:       r_upper[2] <= i_cfg_data;
                pbu_pkg::REG_PERIODIC_MASK: r_mask <= i_cfg_data[pbu_pkg::NUM_AXES-1:0];
                default: begin
                end
            endcase
        end
    end

    // Derived box size and half size.
    always_comb begin
        for (int a = 0; a < pbu_pkg::NUM_AXES; a++) begin
            n_size[a] = pbu_pkg::t_size'(r_upper[a]) - pbu_pkg::t_size'(r_lower[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < pbu_pkg::NUM_AXES; a++) begin
                r_size[a]     <= '0;
                r_half[a]     <= '0;
                r_neg_half[a] <= '0;
            end
        end else begin
            for (int a = 0; a < pbu_pkg::NUM_AXES; a++) begin
                r_size[a]     <= n_size[a];
                r_half[a]     <= pbu_pkg::t_coord'(n_size[a] >>> 1);
                r_neg_half[a] <= -(n_size[a] >>> 1);
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_cmd <= pbu_pkg::t_cmd'(i_s_tuser);
            for (int a = 0; a < pbu_pkg::NUM_AXES; a++) begin
                r_in_coord[a] <= i_s_tdata[a*pbu_pkg::COORD_WIDTH +: pbu_pkg::COORD_WIDTH];
                r_in_img[a]   <= i_s_tdata[pbu_pkg::IMG_BASE + a*pbu_pkg::IMAGE_WIDTH
                                           +: pbu_pkg::IMAGE_WIDTH];
            end
        end
    end

    // Per-axis wrap and minimum-image logic.
    for (genvar g = 0; g < pbu_pkg::NUM_AXES; g++) begin : g_axis
        pbu_pkg::t_wide  c_w;
        pbu_pkg::t_wide  lo_w;
        pbu_pkg::t_wide  hi_w;
        pbu_pkg::t_wide  size_w;
        logic            below;
        logic            above;
        pbu_pkg::t_coord wrap_c;
        pbu_pkg::t_coord step1;
        pbu_pkg::t_wide  step1_w;
        pbu_pkg::t_coord step2;

        assign c_w    = pbu_pkg::t_wide'(r_in_coord[g]);
        assign lo_w   = pbu_pkg::t_wide'(r_lower[g]);
        assign hi_w   = pbu_pkg::t_wide'(r_upper[g]);
        assign size_w = pbu_pkg::t_wide'(r_size[g]);
        assign below  = c_w < lo_w;
        assign above  = c_w > hi_w;
        assign wrap_c = below ? pbu_pkg::clamp_coord(c_w + size_w)
                              : pbu_pkg::clamp_coord(c_w - size_w);

        assign step1   = (r_in_coord[g] > r_half[g]) ? pbu_pkg::clamp_coord(c_w - size_w)
                                                     : r_in_coord[g];
        assign step1_w = pbu_pkg::t_wide'(step1);
        assign step2   = (step1_w < pbu_pkg::t_wide'(r_neg_half[g]))
                         ? pbu_pkg::clamp_coord(step1_w + size_w) : step1;

        always_comb begin
            n_coord[g]   = r_in_coord[g];
            n_img[g]     = r_in_img[g];
            n_wrapped[g] = 1'b0;
            if (r_mask[g]) begin
                case (r_in_cmd)
                    pbu_pkg::CMD_WRAP: begin
                        if (below || above) begin
                            n_coord[g]   = wrap_c;
                            n_wrapped[g] = 1'b1;
                            n_img[g]     = pbu_pkg::clamp_image(
                                pbu_pkg::t_image_wide'(r_in_img[g])
                                + (below ? -pbu_pkg::t_image_wide'(1)
                                         : pbu_pkg::t_image_wide'(1)));
                        end
                    end
                    pbu_pkg::CMD_MIN_IMAGE: begin
                        n_coord[g] = step2;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_cmd     <= r_in_cmd;
            r_out_rebuild <= (r_in_cmd == pbu_pkg::CMD_WRAP) && (|n_wrapped);
            for (int a = 0; a < pbu_pkg::NUM_AXES; a++) begin
                r_out_coord[a] <= n_coord[a];
                r_out_img[a]   <= n_img[a];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_rebuild;

    always_comb begin
        o_m_tdata = '0;
        for (int a = 0; a < pbu_pkg::NUM_AXES; a++) begin
            o_m_tdata[a*pbu_pkg::COORD_WIDTH +: pbu_pkg::COORD_WIDTH] = r_out_coord[a];
            o_m_tdata[pbu_pkg::IMG_BASE + a*pbu_pkg::IMAGE_WIDTH +: pbu_pkg::IMAGE_WIDTH]
                = r_out_img[a];
        end
    end

`include "periodic_boundary_unit_assert.svh"

    `PBU_ASSERT_NOW(a_rebuild_only_wrap, i_clk, i_rst_n,
        r_out_valid && r_out_rebuild, r_out_cmd == pbu_pkg::CMD_WRAP)
    `PBU_ASSERT_NEXT(a_in_held_on_stall, i_clk, i_rst_n,
        r_in_valid && !out_free, r_in_valid && $stable(r_in_coord[0]))
    `PBU_ASSERT_NEXT(a_min_image_keeps_count, i_clk, i_rst_n,
        advance && r_in_cmd == pbu_pkg::CMD_MIN_IMAGE,
        r_out_img[0] == $past(r_in_img[0]) && !r_out_rebuild)
    `PBU_ASSERT_NEXT(a_open_axis_passes, i_clk, i_rst_n,
        advance && !r_mask[0],
        r_out_coord[0] == $past(r_in_coord[0]) && r_out_img[0] == $past(r_in_img[0]))

endmodule
